### hw/rtl/dpc_pkg.sv
package dpc_pkg;

  // Field widths.
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned RUN_W   = 4;
  localparam int unsigned GAP_W   = 26;
  localparam int unsigned WIN_W   = 28;

  // Configuration register indexes.
  localparam logic [3:0] CFG_AGREE_POLLS  = 4'd0;
  localparam logic [3:0] CFG_PRESS_GAP_US = 4'd1;
  localparam logic [3:0] CFG_WINDOW_US    = 4'd2;
  localparam logic [3:0] CFG_START_COUNT  = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [RUN_W-1:0]   AGREE_POLLS_RST  = 4'd5;
  localparam logic [GAP_W-1:0]   PRESS_GAP_RST    = 26'd250000;
  localparam logic [WIN_W-1:0]   WINDOW_US_RST    = 28'd10000000;
  localparam logic [COUNT_W-1:0] START_COUNT_RST  = 32'd0;

  // Largest representable time; a window that would end past it never ends.
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Event from the debouncer to the press tracker.
  typedef struct packed {
    logic step;
    logic believe_press;
  } deb_evt_t;

  // Outcome of one poll from the press tracker.
  typedef struct packed {
    logic               counted;
    logic               refused;
    logic [COUNT_W-1:0] presses;
    logic               window_open;
    logic               window_closed;
  } press_res_t;

endpackage

### hw/rtl/debounced_press_counter_core.sv
// Debounced press counter for an active-low push button. Every input transaction is one poll:
// the raw pin level and the poll time in microseconds. A level is believed after agree_polls
// agreeing polls; a newly believed press is counted unless the previous counted press lies
// less than press_gap_us earlier, in which case press_refused is flagged instead. Each poll
// yields exactly one output transaction carrying the count (start_count plus presses since
// reset, wrapping at 2^32) and the state of the broadcast window, which opens for window_us
// on every counted press and pulses window_closed on the poll that ends it. The block takes
// one poll per clock cycle unless out_tready stalls the result register; a poll passes an
// input and then a result register to reach the output; the rate is set by the state update,
// whose longest path is a 48-bit time subtract and compare feeding the window-end select.
// Configuration writes are accepted in every cycle but must be made only while the block is
// idle.
module debounced_press_counter_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] line_level, [48:1] now_us, [55:49] zero.
  input  logic [55:0] in_tdata,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] press_counted, [1] press_refused, [33:2] count, [34] window_open,
  // [35] window_closed, [39:36] zero.
  output logic [39:0] out_tdata,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [dpc_pkg::RUN_W-1:0]   agree_polls_r;
  logic [dpc_pkg::GAP_W-1:0]   press_gap_r;
  logic [dpc_pkg::WIN_W-1:0]   window_us_r;
  logic [dpc_pkg::COUNT_W-1:0] start_count_r;

  // Input register holding one poll.
  logic                        in_valid_r;
  logic                        level_r;
  logic [dpc_pkg::TIME_W-1:0]  now_r;

  // Result register.
  logic                        out_valid_r;
  logic [39:0]                 out_data_r;
  logic [39:0]                 out_data_nxt;

  logic                        advance;
  dpc_pkg::deb_evt_t           evt;
  dpc_pkg::press_res_t         res;
  logic [dpc_pkg::COUNT_W-1:0] count;

  // The held poll moves on whenever the result register is empty or being drained, so a new
  // transaction is taken in the same cycle and the block keeps one poll per cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agree_polls_r  <= dpc_pkg::AGREE_POLLS_RST;
      press_gap_r    <= dpc_pkg::PRESS_GAP_RST;
      window_us_r    <= dpc_pkg::WINDOW_US_RST;
      start_count_r  <= dpc_pkg::START_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpc_pkg::CFG_AGREE_POLLS:  agree_polls_r  <= cfg_data[dpc_pkg::RUN_W-1:0];
        dpc_pkg::CFG_PRESS_GAP_US: press_gap_r    <= cfg_data[dpc_pkg::GAP_W-1:0];
        dpc_pkg::CFG_WINDOW_US:    window_us_r    <= cfg_data[dpc_pkg::WIN_W-1:0];
        dpc_pkg::CFG_START_COUNT:  start_count_r  <= cfg_data[dpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      level_r <= in_tdata[0];
      now_r   <= in_tdata[48:1];
    end
  end

  // Run counting and belief; the pin is active low.
  dpc_debounce u_debounce (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .down         (!level_r),
    .agree_polls  (agree_polls_r),
    .evt          (evt)
  );

  // Lockout, press count and broadcast window.
  dpc_press u_press (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt          (evt),
    .now_us       (now_r),
    .press_gap_us (press_gap_r),
    .window_us    (window_us_r),
    .res          (res)
  );

  assign count        = start_count_r + res.presses;
  assign out_data_nxt = {4'b0000, res.window_closed, res.window_open, count,
                         res.refused, res.counted};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A poll either counts a press or refuses it, never both.
  a_count_xor_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("press counted and refused on the same poll");

  // A window that closes on this poll is no longer open.
  a_closed_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> !out_tdata[34])
    else $error("window reported closed while still open");

  // A held poll that cannot move on stays held.
  a_hold_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(now_r) && $stable(level_r))
    else $error("held poll lost while the result register was stalled");

  // Nothing is counted unless the debouncer believed a press.
  a_count_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    res.counted |-> evt.believe_press && advance)
    else $error("press counted without a believed press");

endmodule

### hw/rtl/dpc_debounce.sv
// Tracks the raw level run and reports a newly believed press.
module dpc_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      down,
  input  logic [dpc_pkg::RUN_W-1:0] agree_polls,
  output dpc_pkg::deb_evt_t         evt
);

  logic                      last_seen_r, last_seen_nxt;
  logic [dpc_pkg::RUN_W-1:0] run_r, run_nxt;
  logic                      believed_r, believed_nxt;
  logic                      believe;

  always_comb begin
    last_seen_nxt = last_seen_r;
    run_nxt       = run_r;
    if (down != last_seen_r) begin
      last_seen_nxt = down;
      run_nxt       = dpc_pkg::RUN_W'(1);
    end else if (run_r < agree_polls) begin
      run_nxt = run_r + dpc_pkg::RUN_W'(1);
    end
    believe      = (run_nxt >= agree_polls) && (last_seen_nxt != believed_r);
    believed_nxt = believe ? last_seen_nxt : believed_r;
  end

  assign evt.step          = step;
  assign evt.believe_press = step && believe && last_seen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= 1'b0;
      run_r       <= '0;
      believed_r  <= 1'b0;
    end else if (step) begin
      last_seen_r <= last_seen_nxt;
      run_r       <= run_nxt;
      believed_r  <= believed_nxt;
    end
  end

endmodule

### hw/rtl/dpc_press.sv
// Applies the lockout gap, counts presses and runs the broadcast window.
module dpc_press (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dpc_pkg::deb_evt_t           evt,
  input  logic [dpc_pkg::TIME_W-1:0]  now_us,
  input  logic [dpc_pkg::GAP_W-1:0]   press_gap_us,
  input  logic [dpc_pkg::WIN_W-1:0]   window_us,
  output dpc_pkg::press_res_t         res
);

  logic [dpc_pkg::TIME_W-1:0]  last_press_r, last_press_nxt;
  logic [dpc_pkg::COUNT_W-1:0] presses_r, presses_nxt;
  logic [dpc_pkg::TIME_W-1:0]  window_end_r, window_end_nxt;
  logic [dpc_pkg::TIME_W-1:0]  since_last;
  logic [dpc_pkg::TIME_W:0]    end_sum;
  logic [dpc_pkg::TIME_W-1:0]  end_sat;
  logic [dpc_pkg::TIME_W-1:0]  end_mid;
  logic                        locked;
  logic                        counted;
  logic                        closed;

  always_comb begin
    since_last = now_us - last_press_r;
    // A poll earlier than the last press counts as inside the gap.
    locked = (last_press_r != '0) &&
             ((now_us < last_press_r) ||
              (since_last < {{(dpc_pkg::TIME_W-dpc_pkg::GAP_W){1'b0}}, press_gap_us}));
    end_sum = {1'b0, now_us} + {{(dpc_pkg::TIME_W+1-dpc_pkg::WIN_W){1'b0}}, window_us};
    end_sat = end_sum[dpc_pkg::TIME_W] ? dpc_pkg::TIME_MAX : end_sum[dpc_pkg::TIME_W-1:0];

    counted        = evt.believe_press && !locked;
    last_press_nxt = counted ? now_us : last_press_r;
    presses_nxt    = counted ? presses_r + dpc_pkg::COUNT_W'(1) : presses_r;
    end_mid        = counted ? end_sat : window_end_r;

    // The close test follows the press handling of the same poll.
    closed         = (end_mid != '0) && (now_us > end_mid);
    window_end_nxt = closed ? '0 : end_mid;
  end

  assign res.counted       = counted;
  assign res.refused       = evt.believe_press && locked;
  assign res.presses       = presses_nxt;
  assign res.window_open   = (window_end_nxt != '0);
  assign res.window_closed = closed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_press_r <= '0;
      presses_r    <= '0;
      window_end_r <= '0;
    end else if (evt.step) begin
      last_press_r <= last_press_nxt;
      presses_r    <= presses_nxt;
      window_end_r <= window_end_nxt;
    end
  end

endmodule
